// ===== rtl/dsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants for the distinct subsequence counter
// letter alphabet, modulus, command format between the front and back parts
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int AlphabetSize = 26;
  localparam int LetterW      = 5;
  localparam int CountW       = 30;
  localparam int IdxW         = (AlphabetSize > 1) ? $clog2(AlphabetSize) : 1;

  // prime modulus, fits in the count width
  localparam logic [CountW-1:0] Prime = CountW'(1000000007);

  // command queue between front and back, and result queue
  localparam int CmdDepth  = 2;
  localparam int CmdPtrW   = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CmdCntW   = $clog2(CmdDepth + 1);
  localparam int ResDepth  = 2;
  localparam int ResPtrW   = (ResDepth > 1) ? $clog2(ResDepth) : 1;
  localparam int ResCntW   = $clog2(ResDepth + 1);

  typedef enum logic {
    OpSkip,
    OpUpdate
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic            last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dsc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_front: request intake
// classifies each letter and holds it in a short command queue
// ----------------------------------------------------------------------------
module dsc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic [dsc_pkg::LetterW-1:0] letter_i,
  input  wire logic                        last_i,
  output logic                             cmd_valid_o,
  output dsc_pkg::cmd_t                    cmd_o,
  input  wire logic                        cmd_ready_i
);

  dsc_pkg::cmd_t                  cmd_mem_q [dsc_pkg::CmdDepth];
  logic [dsc_pkg::CmdPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [dsc_pkg::CmdPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [dsc_pkg::CmdCntW-1:0]    count_q, count_d;
  dsc_pkg::cmd_t                  cmd_new;
  logic                           wr_en, rd_en;

  // letters outside the alphabet only count for the end flag
  always_comb begin
    cmd_new.op   = (32'(letter_i) < 32'(dsc_pkg::AlphabetSize)) ? dsc_pkg::OpUpdate
                                                               : dsc_pkg::OpSkip;
    cmd_new.idx  = dsc_pkg::IdxW'(letter_i);
    cmd_new.last = last_i;
  end

  assign full_o      = (count_q == dsc_pkg::CmdCntW'(dsc_pkg::CmdDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == dsc_pkg::CmdPtrW'(dsc_pkg::CmdDepth - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == dsc_pkg::CmdPtrW'(dsc_pkg::CmdDepth - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  // occupancy tracks requests in minus commands out
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
    else $error("command queue count lost a request");

endmodule
`default_nettype wire

// ===== rtl/dsc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_back: counting datapath
// per letter end counts and running total, modular update per update command
// ----------------------------------------------------------------------------
module dsc_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cmd_valid_i,
  input  wire dsc_pkg::cmd_t              cmd_i,
  output logic                            cmd_ready_o,
  output logic                            res_valid_o,
  output logic [dsc_pkg::CountW-1:0]      res_o,
  input  wire logic                       res_ready_i
);

  logic [dsc_pkg::CountW-1:0]   ends_q [dsc_pkg::AlphabetSize];
  logic [dsc_pkg::CountW-1:0]   total_q;
  logic [dsc_pkg::CountW-1:0]   old_cnt, fresh, upd_total, next_total;
  logic signed [dsc_pkg::CountW+1:0] sum_s;
  logic                         fire;

  // a command with the end flag needs room for its result
  assign cmd_ready_o = !cmd_i.last || res_ready_i;
  assign res_valid_o = cmd_valid_i && cmd_i.last;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign old_cnt = ends_q[cmd_i.idx];
  assign fresh   = (total_q == dsc_pkg::Prime - 1'b1) ? '0 : total_q + 1'b1;

  // total - old + fresh lies strictly between -p and 2p
  always_comb begin
    sum_s = $signed({2'b00, total_q}) + $signed({2'b00, fresh})
          - $signed({2'b00, old_cnt});
    if (sum_s < 0) begin
      upd_total = dsc_pkg::CountW'(sum_s + $signed({2'b00, dsc_pkg::Prime}));
    end else if (sum_s >= $signed({2'b00, dsc_pkg::Prime})) begin
      upd_total = dsc_pkg::CountW'(sum_s - $signed({2'b00, dsc_pkg::Prime}));
    end else begin
      upd_total = dsc_pkg::CountW'(sum_s);
    end
    next_total = (cmd_i.op == dsc_pkg::OpUpdate) ? upd_total : total_q;
  end

  assign res_o = next_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < dsc_pkg::AlphabetSize; i++) begin
        ends_q[i] <= '0;
      end
    end else if (fire) begin
      if (cmd_i.last) begin
        total_q <= '0;
        for (int i = 0; i < dsc_pkg::AlphabetSize; i++) begin
          ends_q[i] <= '0;
        end
      end else if (cmd_i.op == dsc_pkg::OpUpdate) begin
        total_q          <= upd_total;
        ends_q[cmd_i.idx] <= fresh;
      end
    end
  end

  a_total_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q < dsc_pkg::Prime)
    else $error("running total left the residue range");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_i.last) |=> (total_q == '0))
    else $error("total not cleared after end of string");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && !cmd_ready_o) |=> $stable(total_q))
    else $error("state changed while result queue was full");

endmodule
`default_nettype wire

// ===== rtl/dsc_res_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_res_queue: result queue
// holds finished counts until the consumer pops them
// ----------------------------------------------------------------------------
module dsc_res_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_valid_i,
  output logic                             wr_ready_o,
  input  wire logic [dsc_pkg::CountW-1:0]  wr_data_i,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output logic [dsc_pkg::CountW-1:0]       rd_data_o
);

  logic [dsc_pkg::CountW-1:0]   mem_q [dsc_pkg::ResDepth];
  logic [dsc_pkg::ResPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dsc_pkg::ResCntW-1:0]  count_q;
  logic                         wr_en, rd_en;

  assign wr_ready_o = (count_q != dsc_pkg::ResCntW'(dsc_pkg::ResDepth));
  assign empty_o    = (count_q == '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == dsc_pkg::ResPtrW'(dsc_pkg::ResDepth - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == dsc_pkg::ResPtrW'(dsc_pkg::ResDepth - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && !wr_en) |=> (count_q == $past(count_q) - 1'b1))
    else $error("result queue count lost a pop");

endmodule
`default_nettype wire

// ===== rtl/distinct_subsequence_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_subsequence_counter: distinct subsequence count modulo 1000000007
// streams letters, keeps per letter end counts, emits total on the last one
// ----------------------------------------------------------------------------
//
//   channel   handshake         payload                    direction
//   input     push / full       letter_i[4:0], last_i      in
//   result    empty / pop       distinct_count_o[29:0]     out
//
// one letter per cycle sustained while the back part does not stall; the back
// part does one read-modify-write of a letter count plus one modular add per cycle
// a result shows after its last letter is queued and its count is registered
// reset clears counts, total and both queues at once
// full rises only when the command queue fills; the back part stalls only
// on a last letter while the result queue is full
//
module distinct_subsequence_counter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request side
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [dsc_pkg::LetterW-1:0] letter_i,
  input  wire logic                        last_i,
  // result side
  output logic                             empty,
  input  wire logic                        pop,
  output logic [dsc_pkg::CountW-1:0]       distinct_count_o
);

  // front to back command stream
  logic                        cmd_valid;
  logic                        cmd_ready;
  dsc_pkg::cmd_t               cmd;

  // back to result queue
  logic                        res_valid;
  logic                        res_ready;
  logic [dsc_pkg::CountW-1:0]  res_data;

  // intake: range check on the letter, command queue
  dsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .letter_i    (letter_i),
    .last_i      (last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // counting datapath, clears itself after the end of each string
  dsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res_data),
    .res_ready_i (res_ready)
  );

  // finished counts wait here for the consumer
  dsc_res_queue u_res_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_ready_o (res_ready),
    .wr_data_i  (res_data),
    .empty_o    (empty),
    .pop_i      (pop),
    .rd_data_o  (distinct_count_o)
  );

endmodule
`default_nettype wire
